@@ rtl/lot_pkg.sv @@
// Shared types and constants for the LRU order tracker.
// Depends on nothing; every other file of the block imports it.
package lot_pkg;

  localparam int SLOTS    = 16;
  localparam int ID_W     = 6;
  localparam int CNT_W    = $clog2(SLOTS + 1);
  localparam int RANK_W   = $clog2(SLOTS);
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 3;
  localparam int LIMIT_W  = 5;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  typedef logic [ID_W-1:0]     id_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [RANK_W-1:0]   rank_t;
  typedef logic [LIMIT_W-1:0]  limit_t;
  typedef logic [PADDR_W-1:0]  paddr_t;
  typedef logic [PDATA_W-1:0]  pdata_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_OPEN  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_USE   = 2'd2,
    KIND_QUERY = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_FULL      = 3'd3,
    ST_BAD_RANK  = 3'd4
  } status_t;

  // Register word index of open_limit (byte address 4 * index).
  localparam logic [0:0] REG_OPEN_LIMIT = 1'b0;
  localparam limit_t     OPEN_LIMIT_RST = 5'd16;

  // Per-cell control broadcast from the top level.
  typedef struct packed {
    logic occ;     // cell holds a live entry
    logic remove;  // a removal is under way; cells at or past the hit shift left
    logic load;    // cell takes the event's id
  } cell_ctl_t;

endpackage

@@ rtl/lot_if.sv @@
// Handshake channels of the LRU order tracker: event input and result output.
// Depends on lot_pkg.
interface lot_event_if;
  import lot_pkg::*;
  logic          valid;
  logic          ready;
  kind_t         kind;
  id_t           entry_id;
  rank_t         rank;
  modport source (output valid, kind, entry_id, rank, input ready);
  modport sink   (input valid, kind, entry_id, rank, output ready);
endinterface

interface lot_result_if;
  import lot_pkg::*;
  logic          valid;
  logic          ready;
  status_t       status;
  id_t           found_id;
  logic          found_valid;
  cnt_t          used_count;
  cnt_t          room_left;
  logic          at_limit;
  modport source (output valid, status, found_id, found_valid, used_count, room_left,
                  at_limit, input ready);
  modport sink   (input valid, status, found_id, found_valid, used_count, room_left,
                  at_limit, output ready);
endinterface

@@ rtl/lot_cell.sv @@
// One slot of the ordered id list: compares its id, passes the match flag on
// and shifts in its right neighbor's id on removal. Depends on lot_pkg.
module lot_cell (
  input  logic               clk,
  input  logic               accept,
  input  lot_pkg::id_t       key,
  input  lot_pkg::cell_ctl_t ctl,
  input  logic               seen_in,
  output logic               seen_out,
  input  lot_pkg::id_t       id_right,
  output lot_pkg::id_t       id,
  output lot_pkg::id_t       id_next
);
  import lot_pkg::*;

  logic hit;

  assign hit      = ctl.occ && (id == key);
  assign seen_out = seen_in || hit;

  // The tail load wins over the shift, so a used id lands at the newest end.
  always_comb begin
    priority if (ctl.load) begin
      id_next = key;
    end else if (ctl.remove && seen_out) begin
      id_next = id_right;
    end else begin
      id_next = id;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      id <= id_next;
    end
  end

endmodule

@@ rtl/lot_cfg.sv @@
// APB-style register port holding open_limit.
// Depends on lot_pkg.
module lot_cfg (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  lot_pkg::paddr_t  paddr,
  input  lot_pkg::pdata_t  pwdata,
  output lot_pkg::pdata_t  prdata,
  output logic             pready,
  output lot_pkg::limit_t  open_limit
);
  import lot_pkg::*;

  logic hit;

  assign pready = 1'b1;
  assign hit    = (paddr[PADDR_W-1:2] == REG_OPEN_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      open_limit <= OPEN_LIMIT_RST;
    end else if (psel && penable && pwrite && hit) begin
      open_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  assign prdata = hit ? {{(PDATA_W-LIMIT_W){1'b0}}, open_limit} : '0;

endmodule

@@ rtl/lru_order_tracker.sv @@
// Top level of the LRU order tracker: a chain of id cells, the register port
// and the result register. Depends on lot_pkg, lot_if, lot_cell and lot_cfg.
//
// Usage: events arrive as beats on the evt channel (kind, entry_id, rank) and
// each event yields exactly one beat on the res channel (status, found_id,
// found_valid, used_count, room_left, at_limit). The list lives in a row of
// cells, oldest entry in cell 0. Each cell compares its id against the event's
// id and passes a "match seen" flag to its right neighbor; on close or use,
// every cell at or past the match takes its right neighbor's id, and the tail
// cell takes the id when it is appended. The whole update finishes in the cycle
// the event beat is taken.
// The result beat is registered and appears in the cycle after the event beat is taken.
// Throughput: one event per cycle while the receiver keeps taking results; the
// compare-and-shift chain through all cells is combinational, which sets that figure.
// Stalls: the result waits in the output register while res.ready is low, and
// evt.ready stays low until that result leaves, so nothing is dropped.
// Reset (synchronous, active high) empties the list and sets open_limit to 16.
// open_limit is to be written through the APB-style port only while no event is in
// flight, which the block does not enforce; it only changes room_left and at_limit.
module lru_order_tracker (
  input  logic              clk,
  input  logic              rst,
  lot_event_if.sink         evt,
  lot_result_if.source      res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  lot_pkg::paddr_t   paddr,
  input  lot_pkg::pdata_t   pwdata,
  output lot_pkg::pdata_t   prdata,
  output logic              pready
);
  import lot_pkg::*;

  limit_t    open_limit;
  cnt_t      held_count;
  cnt_t      held_next;
  logic      accept;
  logic      found;
  logic      is_open;
  logic      is_close;
  logic      is_use;
  logic      open_ok;
  logic      remove;
  status_t   status_next;
  id_t       found_id_next;
  logic      found_valid_next;
  cnt_t      room_next;

  logic      seen  [SLOTS+1];
  id_t       ids   [SLOTS];
  id_t       ids_nx[SLOTS];
  id_t       right [SLOTS];
  cell_ctl_t ctl   [SLOTS];

  lot_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .open_limit (open_limit)
  );

  // A new event is taken whenever the result register is empty or draining,
  // and never while reset is held.
  assign evt.ready = !rst && (!res.valid || res.ready);
  assign accept    = evt.valid && evt.ready;

  assign is_open  = (evt.kind == KIND_OPEN);
  assign is_close = (evt.kind == KIND_CLOSE);
  assign is_use   = (evt.kind == KIND_USE);

  // The match flag ripples through the chain; its last value says the id is held.
  assign seen[0] = 1'b0;
  assign found   = seen[SLOTS];
  assign open_ok = is_open && !found && (held_count < CNT_W'(SLOTS));
  assign remove  = (is_close || is_use) && found;

  genvar gi;
  generate
    for (gi = 0; gi < SLOTS; gi++) begin : g_cell
      logic occ;
      logic tail;
      logic free;
      assign occ  = (CNT_W'(gi) < held_count);
      assign tail = (CNT_W'(gi + 1) == held_count);
      assign free = (CNT_W'(gi) == held_count);
      // A used id lands in the last live cell, since the list shrinks by one first.
      assign ctl[gi] = '{occ:    occ,
                         remove: remove,
                         load:   (open_ok && free) || (remove && is_use && tail)};

      if (gi == SLOTS - 1) begin : g_last
        assign right[gi] = '0;
      end else begin : g_mid
        assign right[gi] = ids[gi+1];
      end

      lot_cell u_cell (
        .clk      (clk),
        .accept   (accept),
        .key      (evt.entry_id),
        .ctl      (ctl[gi]),
        .seen_in  (seen[gi]),
        .seen_out (seen[gi+1]),
        .id_right (right[gi]),
        .id       (ids[gi]),
        .id_next  (ids_nx[gi])
      );
    end
  endgenerate

  // Count, status and reported id for the event under way.
  always_comb begin
    held_next        = held_count;
    status_next      = ST_OK;
    found_id_next    = '0;
    found_valid_next = 1'b0;
    unique case (evt.kind)
      KIND_OPEN: begin
        if (found) begin
          status_next = ST_DUPLICATE;
        end else if (!open_ok) begin
          status_next = ST_FULL;
        end else begin
          held_next = held_count + CNT_W'(1);
        end
      end
      KIND_CLOSE: begin
        if (!found) begin
          status_next = ST_NOT_FOUND;
        end else begin
          held_next = held_count - CNT_W'(1);
        end
      end
      KIND_USE: begin
        if (!found) begin
          status_next = ST_NOT_FOUND;
        end
      end
      KIND_QUERY: begin
        if (CNT_W'(evt.rank) < held_count) begin
          found_id_next    = ids[evt.rank];
          found_valid_next = 1'b1;
        end else begin
          status_next = ST_BAD_RANK;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
    if (evt.kind != KIND_QUERY && held_next != '0) begin
      found_id_next    = ids_nx[0];
      found_valid_next = 1'b1;
    end
  end

  assign room_next = (CNT_W'(open_limit) > held_next) ?
                     CNT_W'(open_limit) - held_next : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      res.valid  <= 1'b0;
    end else begin
      if (accept) begin
        held_count <= held_next;
        res.valid  <= 1'b1;
      end else if (res.ready) begin
        res.valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res.status      <= status_next;
      res.found_id    <= found_id_next;
      res.found_valid <= found_valid_next;
      res.used_count  <= held_next;
      res.room_left   <= room_next;
      res.at_limit    <= (held_next >= CNT_W'(open_limit));
    end
  end

endmodule
